// ----- rtl/core/ftlb_pkg.sv -----
package ftlb_pkg;

  // Sizes of the translation buffer.
  localparam int ENTRIES    = 16;
  localparam int PAGE_BITS  = 20;
  localparam int FRAME_BITS = 16;
  localparam int PTR_BITS   = $clog2(ENTRIES);

  // Stream widths, rounded up to whole bytes.
  localparam int S_DATA_W = ((PAGE_BITS + FRAME_BITS + 7) / 8) * 8;
  localparam int M_DATA_W = ((FRAME_BITS + 7) / 8) * 8;

  // Command codes carried on the input tuser.
  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXE
  } state_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                  cmp;
    logic                  exe;
    cmd_t                  cmd;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
    logic                  any_match;
    logic                  all_valid;
  } ftlb_ctl_t;

  // Data handed from one cell to its higher-numbered neighbor.
  typedef struct packed {
    logic                  hit;
    logic                  free_seen;
    logic [FRAME_BITS-1:0] frame;
  } ftlb_link_t;

endpackage

// ----- rtl/core/ftlb_cell.sv -----
module ftlb_cell
  import ftlb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  ftlb_ctl_t  ctl,
  input  logic       victim,
  input  ftlb_link_t link_in,
  output ftlb_link_t link_out,
  output logic       match,
  output logic       valid
);

  logic [PAGE_BITS-1:0]  page;
  logic [FRAME_BITS-1:0] frame;
  logic                  take;

  // A new page lands here if this is the first free slot, or the FIFO victim when full.
  always_comb begin
    take = 1'b0;
    if (ctl.cmd == CMD_INSERT && !ctl.any_match) begin
      if (ctl.all_valid) begin
        take = victim;
      end else begin
        take = !valid && !link_in.free_seen;
      end
    end
  end

  // Pass hit, frame and free-slot information on to the next cell.
  always_comb begin
    link_out.hit       = link_in.hit | match;
    link_out.free_seen = link_in.free_seen | !valid;
    link_out.frame     = link_in.frame | (match ? frame : '0);
  end

  // Valid bit of this entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.exe) begin
      unique case (ctl.cmd)
        CMD_LOOKUP: valid <= valid;
        CMD_INSERT: valid <= valid | take;
        CMD_REMOVE: valid <= valid & !match;
        CMD_CLEAR:  valid <= 1'b0;
        default:    valid <= valid;
      endcase
    end
  end

  // Match flag, registered in the compare cycle and used in the execute cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.cmp) begin
      match <= valid && (page == ctl.page);
    end
  end

  // Page and frame payload of this entry.
  always_ff @(posedge clk) begin
    if (ctl.exe && ctl.cmd == CMD_INSERT) begin
      if (take) begin
        page  <= ctl.page;
        frame <= ctl.frame;
      end else if (match) begin
        frame <= ctl.frame;
      end
    end
  end

endmodule

// ----- rtl/core/fifo_tlb.sv -----
// Fully associative translation buffer with FIFO replacement.
// Input channel s_*: one command word per transfer; s_tuser holds the command
// (lookup, insert, remove, clear all), s_tdata holds page and frame.
// Output channel m_*: one result word per command; m_tuser is the hit flag and
// m_tdata the frame of the matching entry on a lookup hit, zero otherwise.
// Each entry lives in its own cell; the cells sit in a row and hand hit, frame
// and free-slot flags to their neighbor, so the lowest free slot is found in
// the same cycle that all entries act on the command.
// A command passes through capture, a compare cycle in which every cell
// registers its page match, and an execute cycle that updates the cells and
// loads the result register. One command is in flight at a time, so a new
// command is accepted only after the previous one has executed.
// A new command is taken while the previous result still waits in the output
// register; if the receiver stalls, the execute cycle holds until it is free.
// Reset clears all valid bits, the replace pointer and both channels; no
// clearing pass is needed.
module fifo_tlb
  import ftlb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // s_tdata fields from bit 0: page, frame, zero fill.
  input  logic [S_DATA_W-1:0] s_tdata,
  // s_tuser fields from bit 0: cmd.
  input  logic [1:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // m_tdata fields from bit 0: frame_out.
  output logic [M_DATA_W-1:0] m_tdata,
  // m_tuser fields from bit 0: hit.
  output logic                m_tuser
);

  state_t                state;
  state_t                state_next;
  cmd_t                  cmd;
  logic [PAGE_BITS-1:0]  page;
  logic [FRAME_BITS-1:0] frame;
  logic [PTR_BITS-1:0]   ptr;
  logic                  exe_go;
  logic                  hit_q;
  logic [FRAME_BITS-1:0] frame_q;
  ftlb_ctl_t             ctl;
  ftlb_link_t            link [ENTRIES+1];
  logic [ENTRIES-1:0]    match_vec;
  logic [ENTRIES-1:0]    valid_vec;
  logic [ENTRIES-1:0]    victim_vec;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    exe_go     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = ST_EXE;
      end
      ST_EXE: begin
        exe_go = !m_tvalid || m_tready;
        if (exe_go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Capture the accepted command.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd   <= cmd_t'(s_tuser);
      page  <= s_tdata[PAGE_BITS-1:0];
      frame <= s_tdata[PAGE_BITS+FRAME_BITS-1:PAGE_BITS];
    end
  end

  // Broadcast control to the cells.
  always_comb begin
    ctl.cmp       = (state == ST_CMP);
    ctl.exe       = exe_go;
    ctl.cmd       = cmd;
    ctl.page      = page;
    ctl.frame     = frame;
    ctl.any_match = |match_vec;
    ctl.all_valid = &valid_vec;
  end

  assign link[0] = '0;

  // Row of entry cells.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign victim_vec[i] = (ptr == PTR_BITS'(i));

    ftlb_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .victim   (victim_vec[i]),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .match    (match_vec[i]),
      .valid    (valid_vec[i])
    );
  end

  // FIFO replace pointer advances only when a full buffer loses its victim.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (exe_go && cmd == CMD_INSERT && !ctl.any_match && ctl.all_valid) begin
      if (ptr == PTR_BITS'(ENTRIES - 1)) begin
        ptr <= '0;
      end else begin
        ptr <= ptr + PTR_BITS'(1);
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exe_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload; only a lookup reports a hit.
  always_ff @(posedge clk) begin
    if (exe_go) begin
      hit_q   <= (cmd == CMD_LOOKUP) && link[ENTRIES].hit;
      frame_q <= (cmd == CMD_LOOKUP) ? link[ENTRIES].frame : '0;
    end
  end

  assign m_tuser = hit_q;
  assign m_tdata = M_DATA_W'(frame_q);

`ifndef SYNTHESIS
  // No two entries ever hold the same valid page.
  a_one_match: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXE) |-> $onehot0(match_vec))
    else $error("more than one entry matched");

  // A clear leaves every entry invalid.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (exe_go && cmd == CMD_CLEAR) |=> (valid_vec == '0))
    else $error("entries still valid after clear");

  // The replace pointer moves only on an executed insert.
  a_ptr: assert property (@(posedge clk) disable iff (rst)
    !(exe_go && cmd == CMD_INSERT) |=> $stable(ptr))
    else $error("replace pointer moved without insert");

  // An insert never reduces the number of valid entries.
  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    (exe_go && cmd == CMD_INSERT) |=> ($countones(valid_vec) >= $countones($past(valid_vec))))
    else $error("insert lost a valid entry");
`endif

endmodule
